>>> rtl/elv_pkg.sv
// Package for the extension list validator: status codes, controller states,
// command/status structs between controller and datapath, default table depth.
// No dependencies.
package elv_pkg;

    // default depth of the seen-type table
    localparam int MAX_EXTENSIONS_DEF = 128;

    // final status codes
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_ENCODING = 2'd1,
        STAT_PROTOCOL = 2'd2
    } status_t;

    // controller states
    typedef enum logic {
        CS_RUN,
        CS_SEARCH
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic take;      // an item is accepted this cycle
        logic search;    // step the duplicate search
    } elv_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;      // result register can take a new item
        logic start_search;  // item in flight needs a table search
        logic search_done;   // last table entry is compared this cycle
    } elv_stat_t;

endpackage

>>> rtl/elv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module elv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write one entry, read one entry into the output register
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/elv_ctrl.sv
// Controller for the extension list validator: accepts items or steps the
// duplicate search. Depends on elv_pkg.
module elv_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output elv_pkg::elv_cmd_t   cmd,
    input  elv_pkg::elv_stat_t  stat
);
    import elv_pkg::*;

    ctrl_state_t state_reg, state_next;

    // hold the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd.take   = 1'b0;
        cmd.search = 1'b0;
        case (state_reg)
            CS_RUN: begin
                s_ready  = stat.out_free;
                cmd.take = s_valid && stat.out_free;
                if (cmd.take && stat.start_search) begin
                    state_next = CS_SEARCH;
                end
            end
            CS_SEARCH: begin
                cmd.search = 1'b1;
                if (stat.search_done) begin
                    state_next = CS_RUN;
                end
            end
            default: begin
                state_next = CS_RUN;
            end
        endcase
    end

endmodule

>>> rtl/elv_dp.sv
// Datapath for the extension list validator: header parsing, value byte
// count, seen-type table search, status latch and result register.
// Depends on elv_pkg and elv_ram.
module elv_dp #(
    parameter int MAX_EXTENSIONS = elv_pkg::MAX_EXTENSIONS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  elv_pkg::elv_cmd_t   cmd,
    output elv_pkg::elv_stat_t  stat,
    input  logic [7:0]          s_in_byte,
    input  logic                s_no_byte,
    input  logic                s_block_end,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_ext_valid,
    output logic [15:0]         m_ext_type,
    output logic [15:0]         m_value_length,
    output logic                m_done_res,
    output logic [1:0]          m_status
);
    import elv_pkg::*;

    localparam int CW = $clog2(MAX_EXTENSIONS + 1);
    localparam int AW = (MAX_EXTENSIONS > 1) ? $clog2(MAX_EXTENSIONS) : 1;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENSIONS);

    // block state
    logic [CW-1:0] count_reg, count_next;
    logic          phase_reg, phase_next;
    logic [1:0]    hidx_reg, hidx_next;
    logic [15:0]   type_reg, type_next;
    logic [15:0]   len_reg, len_next;
    logic [15:0]   rem_reg, rem_next;
    logic          fault_reg, fault_next;
    status_t       status_reg, status_next;
    // search state
    logic [CW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    // result register
    logic          mv_reg, mv_next;
    logic          oext_reg, oext_next;
    logic [15:0]   otype_reg, otype_next;
    logic [15:0]   olen_reg, olen_next;
    logic          odone_reg, odone_next;
    logic [1:0]    ost_reg, ost_next;

    // table ports
    logic          wr_en;
    logic          rd_en;
    logic [15:0]   rd_data;

    // working values for the item in flight
    logic          acc;
    logic          hdr_active;
    status_t       fin_st;

    elv_ram #(
        .WIDTH (16),
        .DEPTH (MAX_EXTENSIONS)
    ) u_seen (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (type_reg),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // status towards the controller
    assign hdr_active = !s_no_byte && (status_reg == STAT_OK) && !phase_reg;
    always_comb begin
        stat.out_free     = !mv_reg || m_ready;
        stat.start_search = hdr_active && (hidx_reg == 2'd1) && !s_block_end
                            && (count_reg != '0) && (count_reg < CNT_MAX);
        stat.search_done  = (idx_reg == count_reg);
    end

    // parse, search and result logic
    always_comb begin
        count_next  = count_reg;
        phase_next  = phase_reg;
        hidx_next   = hidx_reg;
        type_next   = type_reg;
        len_next    = len_reg;
        rem_next    = rem_reg;
        fault_next  = fault_reg;
        status_next = status_reg;
        idx_next    = idx_reg;
        pend_next   = pend_reg;
        mv_next     = mv_reg;
        oext_next   = oext_reg;
        otype_next  = otype_reg;
        olen_next   = olen_reg;
        odone_next  = odone_reg;
        ost_next    = ost_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        acc         = 1'b0;
        fin_st      = STAT_OK;

        // drain the result register
        if (m_ready) begin
            mv_next = 1'b0;
        end

        if (cmd.take) begin
            idx_next  = '0;
            pend_next = 1'b0;
            if (!s_no_byte && (status_reg == STAT_OK)) begin
                if (!phase_reg) begin
                    case (hidx_reg)
                        2'd0: begin
                            type_next = {s_in_byte, 8'h00};
                            hidx_next = 2'd1;
                        end
                        2'd1: begin
                            type_next  = {type_reg[15:8], s_in_byte};
                            fault_next = !(count_reg < CNT_MAX);
                            hidx_next  = 2'd2;
                        end
                        2'd2: begin
                            len_next  = {s_in_byte, 8'h00};
                            hidx_next = 2'd3;
                        end
                        default: begin
                            len_next  = {len_reg[15:8], s_in_byte};
                            hidx_next = 2'd0;
                            if (len_next == 16'd0) begin
                                acc = 1'b1;
                            end else begin
                                phase_next = 1'b1;
                                rem_next   = len_next;
                            end
                        end
                    endcase
                end else begin
                    rem_next = rem_reg - 16'd1;
                    if (rem_next == 16'd0) begin
                        phase_next = 1'b0;
                        acc        = 1'b1;
                    end
                end
                // finish the extension: refuse it or record its type
                if (acc) begin
                    if (fault_reg) begin
                        acc         = 1'b0;
                        fault_next  = 1'b0;
                        status_next = STAT_PROTOCOL;
                    end else if (count_reg < CNT_MAX) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end

            // load the result
            if (acc || s_block_end) begin
                mv_next    = 1'b1;
                oext_next  = acc;
                otype_next = acc ? type_reg : 16'd0;
                olen_next  = acc ? len_next : 16'd0;
                odone_next = s_block_end;
                ost_next   = STAT_OK;
            end

            // close the block: flag a truncated extension, then clear
            if (s_block_end) begin
                fin_st = status_next;
                if ((fin_st == STAT_OK) && (phase_next || (hidx_next != 2'd0))) begin
                    fin_st = STAT_ENCODING;
                end
                ost_next    = fin_st;
                count_next  = '0;
                phase_next  = 1'b0;
                hidx_next   = 2'd0;
                type_next   = 16'd0;
                len_next    = 16'd0;
                rem_next    = 16'd0;
                fault_next  = 1'b0;
                status_next = STAT_OK;
            end
        end

        // step the search: issue one read, compare the previous one
        if (cmd.search) begin
            if (idx_reg < count_reg) begin
                rd_en     = 1'b1;
                idx_next  = idx_reg + 1'b1;
                pend_next = 1'b1;
            end else begin
                pend_next = 1'b0;
            end
            if (pend_reg && (rd_data == type_reg)) begin
                fault_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            phase_reg  <= 1'b0;
            hidx_reg   <= 2'd0;
            rem_reg    <= 16'd0;
            fault_reg  <= 1'b0;
            status_reg <= STAT_OK;
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
            mv_reg     <= 1'b0;
            type_reg   <= 16'd0;
            len_reg    <= 16'd0;
        end else begin
            count_reg  <= count_next;
            phase_reg  <= phase_next;
            hidx_reg   <= hidx_next;
            rem_reg    <= rem_next;
            fault_reg  <= fault_next;
            status_reg <= status_next;
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
            mv_reg     <= mv_next;
            type_reg   <= type_next;
            len_reg    <= len_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        oext_reg  <= oext_next;
        otype_reg <= otype_next;
        olen_reg  <= olen_next;
        odone_reg <= odone_next;
        ost_reg   <= ost_next;
    end

    assign m_valid        = mv_reg;
    assign m_ext_valid    = oext_reg;
    assign m_ext_type     = otype_reg;
    assign m_value_length = olen_reg;
    assign m_done_res     = odone_reg;
    assign m_status       = ost_reg;

endmodule

>>> rtl/extension_list_validator.sv
// Top level of the extension list validator: controller plus datapath.
// Depends on elv_pkg, elv_ctrl, elv_dp (and elv_ram below it).
//
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | s_in_byte, s_no_byte, s_block_end
//  m_      | out       | m_valid / m_ready | m_ext_valid, m_ext_type,
//          |           |                   | m_value_length, m_done_res, m_status
//
// One item per cycle while the output register can take it, except a second
// type byte that needs a duplicate search (table neither empty nor full, no
// error latched, not the last item of the block): after it, s_ready stays low
// while the seen-type table RAM is read one entry a cycle on its single read port.
// Reset is synchronous and active low; the table needs no clearing pass.
// A result waits in the output register; s_ready drops only while that
// register is full and m_ready is low, or during the table search.
module extension_list_validator #(
    parameter int MAX_EXTENSIONS = elv_pkg::MAX_EXTENSIONS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_no_byte,
    input  logic        s_block_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ext_valid,
    output logic [15:0] m_ext_type,
    output logic [15:0] m_value_length,
    output logic        m_done_res,
    output logic [1:0]  m_status
);
    import elv_pkg::*;

    elv_cmd_t  cmd;
    elv_stat_t stat;

    elv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    elv_dp #(
        .MAX_EXTENSIONS (MAX_EXTENSIONS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_in_byte      (s_in_byte),
        .s_no_byte      (s_no_byte),
        .s_block_end    (s_block_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ext_valid    (m_ext_valid),
        .m_ext_type     (m_ext_type),
        .m_value_length (m_value_length),
        .m_done_res     (m_done_res),
        .m_status       (m_status)
    );

endmodule
